/* rtl/tpr_pkg.sv */
// Shared types and constants for the tachometer period-to-rpm block.
`default_nettype none
package tpr_pkg;

   localparam int unsigned TIME_W = 32;
   localparam int unsigned RPM_W  = 16;
   localparam int unsigned PPR_W  = 8;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [TIME_W-1:0] TICKS_PER_MINUTE_DEF = 32'd60000000;
   localparam int unsigned       QUEUE_DEPTH_DEF      = 2;

   localparam logic [TIME_W-1:0] MIN_PERIOD_RST    = 32'd10000;
   localparam logic [PPR_W-1:0]  EDGES_PER_REV_RST = 8'd1;
   localparam logic [RPM_W-1:0]  MAX_RPM_RST       = 16'd5000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIN_PERIOD    = 2'd0,
      CSR_EDGES_PER_REV = 2'd1,
      CSR_MAX_RPM       = 2'd2
   } csr_index_type;

   // Settings the back end needs while it converts a period
   typedef struct packed {
      logic [PPR_W-1:0] edges_per_rev;
      logic [RPM_W-1:0] max_rpm;
   } back_cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE       = 4'b0001,
      ST_DIV_PERIOD = 4'b0010,
      ST_DIV_PULSES = 4'b0100,
      ST_DONE       = 4'b1000
   } back_state_type;

endpackage
`default_nettype wire

/* rtl/tpr_front.sv */
// Edge front end: debounce against the last edge that passed the debounce and queue the period.
`default_nettype none
module tpr_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [tpr_pkg::TIME_W-1:0] req_tdata,
   input  wire logic [tpr_pkg::TIME_W-1:0] min_period,
   input  wire logic                      queue_full,
   output logic                           push,
   output logic [tpr_pkg::TIME_W-1:0]     push_period
);
   import tpr_pkg::*;

   logic [TIME_W-1:0] last_edge_ff;
   logic [TIME_W-1:0] last_edge_in;
   logic              accept;
   logic              keep;

   assign req_tready  = !queue_full;
   assign accept      = req_tvalid && req_tready;
   // wrapping difference covers a timer rollover between edges
   assign push_period = req_tdata - last_edge_ff;
   assign keep        = push_period >= min_period;
   assign push        = accept && keep;

   always_comb begin
      last_edge_in = last_edge_ff;
      if (push) begin
         last_edge_in = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_edge_ff <= '0;
      end else begin
         last_edge_ff <= last_edge_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/tpr_fifo.sv */
// Short period queue between the front end and the divider back end.
`default_nettype none
module tpr_fifo #(
   parameter int unsigned DEPTH = tpr_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire logic [tpr_pkg::TIME_W-1:0] push_data,
   input  wire logic                      pop,
   output logic [tpr_pkg::TIME_W-1:0]     pop_data,
   output logic                           full,
   output logic                           empty
);
   import tpr_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [TIME_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full     = count_ff == FULL_CNT;
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/tpr_back.sv */
// Divider back end: two radix-4 restoring divisions, limit check, result register.
`default_nettype none
module tpr_back #(
   parameter logic [tpr_pkg::TIME_W-1:0] TICKS_PER_MINUTE = tpr_pkg::TICKS_PER_MINUTE_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire tpr_pkg::back_cfg_type     cfg,
   input  wire logic                      queue_empty,
   input  wire logic [tpr_pkg::TIME_W-1:0] queue_data,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [tpr_pkg::RPM_W-1:0]      rsp_rpm,
   output logic [tpr_pkg::TIME_W-1:0]     rsp_period
);
   import tpr_pkg::*;

   localparam int unsigned ITERS = TIME_W / 2;
   localparam int unsigned CNT_W = $clog2(ITERS);
   localparam logic [CNT_W-1:0] LAST_ITER = CNT_W'(ITERS - 1);

   // One restoring step: returns {remainder, quotient/dividend shift register}
   function automatic logic [2*TIME_W-1:0] div_step(
      input logic [TIME_W-1:0] rem,
      input logic [TIME_W-1:0] num,
      input logic [TIME_W-1:0] den
   );
      logic [TIME_W:0]   sh;
      logic [TIME_W:0]   diff;
      logic              ge;
      logic [TIME_W-1:0] rem_n;
      sh    = {rem, num[TIME_W-1]};
      diff  = sh - {1'b0, den};
      ge    = sh >= {1'b0, den};
      rem_n = ge ? diff[TIME_W-1:0] : sh[TIME_W-1:0];
      return {rem_n, num[TIME_W-2:0], ge};
   endfunction

   back_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [TIME_W-1:0] rem_ff, rem_in;
   logic [TIME_W-1:0] num_ff, num_in;
   logic [TIME_W-1:0] den_ff, den_in;
   logic [TIME_W-1:0] period_ff, period_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RPM_W-1:0]  rsp_rpm_ff, rsp_rpm_in;
   logic [TIME_W-1:0] rsp_period_ff, rsp_period_in;
   logic [2*TIME_W-1:0] step1;
   logic [2*TIME_W-1:0] step2;
   logic              slot_free;
   logic              in_range;

   assign step1     = div_step(rem_ff, num_ff, den_ff);
   assign step2     = div_step(step1[2*TIME_W-1:TIME_W], step1[TIME_W-1:0], den_ff);
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign in_range  = num_ff <= {{(TIME_W-RPM_W){1'b0}}, cfg.max_rpm};
   assign pop       = (state_ff == ST_IDLE) && !queue_empty;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_rpm    = rsp_rpm_ff;
   assign rsp_period = rsp_period_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rem_in        = rem_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      period_in     = period_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_rpm_in    = rsp_rpm_ff;
      rsp_period_in = rsp_period_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               period_in = queue_data;
               num_in    = TICKS_PER_MINUTE;
               rem_in    = '0;
               den_in    = queue_data;
               cnt_in    = '0;
               state_in  = ST_DIV_PERIOD;
            end
         end
         ST_DIV_PERIOD: begin
            rem_in = step2[2*TIME_W-1:TIME_W];
            num_in = step2[TIME_W-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_ITER) begin
               // restart on the quotient, divide by pulses per revolution
               rem_in   = '0;
               den_in   = {{(TIME_W-PPR_W){1'b0}}, cfg.edges_per_rev};
               cnt_in   = '0;
               state_in = ST_DIV_PULSES;
            end
         end
         ST_DIV_PULSES: begin
            rem_in = step2[2*TIME_W-1:TIME_W];
            num_in = step2[TIME_W-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_ITER) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // drop readings above the limit, otherwise wait for the output slot
            if (!in_range) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_rpm_in    = num_ff[RPM_W-1:0];
               rsp_period_in = period_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      rem_ff        <= rem_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      period_ff     <= period_in;
      rsp_rpm_ff    <= rsp_rpm_in;
      rsp_period_ff <= rsp_period_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> state_ff == ST_DIV_PERIOD)
      else $error("period taken from queue outside idle");

   a_load_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result loaded without a finished division");

   a_rpm_limit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> rsp_rpm_ff <= cfg.max_rpm)
      else $error("result above speed limit");

   a_load_next_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> state_ff == ST_IDLE)
      else $error("back end did not return to idle after a result");

endmodule
`default_nettype wire

/* rtl/tachometer_period_to_rpm.sv */
// Top level of the tachometer: settings registers, front end, period queue, back end.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_tvalid/tready    | edge_time
//  rsp     | out       | rsp_tvalid/tready    | rpm, period
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// An edge is taken whenever the period queue has room; a debounced edge passes the
// back end in order: a load step in idle, sixteen radix-4 steps of the shared
// divider for ticks per minute over the period, sixteen for pulses per revolution,
// and a check and register step that waits for a free output slot. Synchronous reset
// clears the last edge time, queue, back-end state and output valid, and restores the
// register defaults. A stalled result holds in the output register while the back end
// finishes one more period and up to QUEUE_DEPTH further periods queue.
`default_nettype none
module tachometer_period_to_rpm #(
   parameter logic [tpr_pkg::TIME_W-1:0] TICKS_PER_MINUTE = tpr_pkg::TICKS_PER_MINUTE_DEF,
   parameter int unsigned QUEUE_DEPTH = tpr_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [tpr_pkg::TIME_W-1:0]      req_tdata,   // [31:0] edge_time
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [47:0]                         rsp_tdata,   // [15:0] rpm, [47:16] period
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [tpr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tpr_pkg::TIME_W-1:0]      csr_data
);
   import tpr_pkg::*;

   logic [TIME_W-1:0] min_period_ff, min_period_in;
   logic [PPR_W-1:0]  edges_per_rev_ff, edges_per_rev_in;
   logic [RPM_W-1:0]  max_rpm_ff, max_rpm_in;
   back_cfg_type      back_cfg;
   logic              csr_write;
   logic              push;
   logic [TIME_W-1:0] push_period;
   logic              pop;
   logic [TIME_W-1:0] queue_data;
   logic              queue_full;
   logic              queue_empty;
   logic [RPM_W-1:0]  rsp_rpm;
   logic [TIME_W-1:0] rsp_period;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      min_period_in    = min_period_ff;
      edges_per_rev_in = edges_per_rev_ff;
      max_rpm_in       = max_rpm_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_MIN_PERIOD:    min_period_in    = csr_data;
            CSR_EDGES_PER_REV: edges_per_rev_in = csr_data[PPR_W-1:0];
            CSR_MAX_RPM:       max_rpm_in       = csr_data[RPM_W-1:0];
            default: begin
               // ignore writes to unused indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_period_ff    <= MIN_PERIOD_RST;
         edges_per_rev_ff <= EDGES_PER_REV_RST;
         max_rpm_ff       <= MAX_RPM_RST;
      end else begin
         min_period_ff    <= min_period_in;
         edges_per_rev_ff <= edges_per_rev_in;
         max_rpm_ff       <= max_rpm_in;
      end
   end

   assign back_cfg.edges_per_rev = edges_per_rev_ff;
   assign back_cfg.max_rpm       = max_rpm_ff;

   tpr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .min_period  (min_period_ff),
      .queue_full  (queue_full),
      .push        (push),
      .push_period (push_period)
   );

   tpr_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_period),
      .pop       (pop),
      .pop_data  (queue_data),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   tpr_back #(
      .TICKS_PER_MINUTE (TICKS_PER_MINUTE)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (back_cfg),
      .queue_empty (queue_empty),
      .queue_data  (queue_data),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_rpm     (rsp_rpm),
      .rsp_period  (rsp_period)
   );

   assign rsp_tdata = {rsp_period, rsp_rpm};

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking stream testbench for the period-to-rpm tachometer block.
`timescale 1ns / 1ps
module tb_top;
   import tpr_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 150;   // three queued edges through the divider, plus margin
   localparam int RANDOM_PHASES  = 8;
   localparam int EDGES_PER_PHASE = 225;

   typedef struct packed {
      logic [RPM_W-1:0]  rpm;
      logic [TIME_W-1:0] period;
   } speed_reading_type;

   typedef struct {
      logic [TIME_W-1:0] min_period;
      logic [PPR_W-1:0]  edges_per_rev;
      logic [RPM_W-1:0]  max_rpm;
   } speed_setting_type;

   typedef enum int {RX_STREAM, RX_JITTER, RX_CHOPPY, RX_BLOCKED} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [TIME_W-1:0]   req_tdata = '0;   // [31:0] edge_time
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [47:0]         rsp_tdata;        // [15:0] rpm, [47:16] period
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   csr_index_type       csr_index = CSR_MIN_PERIOD;
   logic [TIME_W-1:0]   csr_data = '0;

   // Mirror of the block's registers and edge state
   logic [TIME_W-1:0]   cfg_min_period = MIN_PERIOD_RST;
   logic [PPR_W-1:0]    cfg_edges_per_rev = EDGES_PER_REV_RST;
   logic [RPM_W-1:0]    cfg_max_rpm = MAX_RPM_RST;
   logic [TIME_W-1:0]   last_edge_time = '0;

   logic [TIME_W-1:0]   pending_edges[$];
   speed_reading_type   expected_readings[$];
   logic [TIME_W-1:0]   gen_time;

   int burst_left = 0;
   int gap_left = 0;
   int stall_left = 0;
   int mode_cycles = 0;
   rx_mode_type rx_mode = RX_STREAM;
   int idle_cycles = 0;

   int edges_taken = 0;
   int readings_due = 0;
   int readings_checked = 0;
   int csr_writes = 0;
   int settings_run = 0;
   int mismatch_count = 0;

   speed_setting_type phase_setting;

   tachometer_period_to_rpm dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Debounce, divide, and gate one edge against the mirrored settings
   task automatic predict_reading(input logic [TIME_W-1:0] edge_time);
      logic [TIME_W-1:0] spacing;
      logic [TIME_W-1:0] per_minute;
      logic [TIME_W-1:0] speed;
      speed_reading_type reading;
      edges_taken++;
      spacing = edge_time - last_edge_time;
      if (spacing < cfg_min_period) return;
      last_edge_time = edge_time;
      per_minute = (spacing == '0) ? '1 : TICKS_PER_MINUTE_DEF / spacing;
      speed = (cfg_edges_per_rev == '0) ? '1 : per_minute / {24'd0, cfg_edges_per_rev};
      if (speed > {16'd0, cfg_max_rpm}) return;
      reading.rpm = speed[RPM_W-1:0];
      reading.period = spacing;
      expected_readings.push_back(reading);
      readings_due++;
   endtask

   task automatic log_mismatch(input string msg);
      if (mismatch_count < 10) $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_reading(input logic [47:0] beat);
      speed_reading_type want;
      if (expected_readings.size() == 0) begin
         log_mismatch($sformatf("unexpected reading rpm=%0d period=%0d",
                                beat[15:0], beat[47:16]));
      end else begin
         want = expected_readings.pop_front();
         readings_checked++;
         if (beat[15:0] !== want.rpm)
            log_mismatch($sformatf("rpm expected %0d got %0d (period %0d)",
                                   want.rpm, beat[15:0], want.period));
         if (beat[47:16] !== want.period)
            log_mismatch($sformatf("period expected %0d got %0d",
                                   want.period, beat[47:16]));
      end
   endtask

   // Edge source: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) predict_reading(req_tdata);
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_edges.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= pending_edges.pop_front();
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Reading sink: stall behavior switches at random between stream, jitter, choppy and blocked modes
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_reading(rsp_tdata);
         mode_cycles++;
         if (mode_cycles >= 400) begin
            mode_cycles = 0;
            rx_mode = rx_mode_type'($urandom_range(0, 3));
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            case (rx_mode)
               RX_JITTER: if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(1, 3);
               RX_CHOPPY: if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(5, 40);
               RX_BLOCKED: if ($urandom_range(0, 19) == 0) stall_left = $urandom_range(40, 80);
               default: ;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("FAIL");
         $finish;
      end
   end

   task automatic write_csr(input csr_index_type idx, input logic [TIME_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MIN_PERIOD:    cfg_min_period = value;
         CSR_EDGES_PER_REV: cfg_edges_per_rev = value[PPR_W-1:0];
         CSR_MAX_RPM:       cfg_max_rpm = value[RPM_W-1:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic apply_setting(input speed_setting_type s);
      write_csr(CSR_MIN_PERIOD, s.min_period);
      write_csr(CSR_EDGES_PER_REV, {24'd0, s.edges_per_rev});
      write_csr(CSR_MAX_RPM, {16'd0, s.max_rpm});
      settings_run++;
      @(negedge clock);
   endtask

   // Hold until every edge is taken and every reading is back, then let the divider drain
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_edges.size() != 0 || req_tvalid || expected_readings.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly in-range edge trains, plus bounces, too-fast edges and raw timer noise
   task automatic queue_edges(input int count);
      longint unsigned floor_p;
      longint unsigned fast_limit;
      logic [TIME_W-1:0] stamp;
      int pick;
      floor_p = cfg_min_period;
      if (cfg_edges_per_rev != '0) begin
         fast_limit = 64'(TICKS_PER_MINUTE_DEF)
                      / ((64'(cfg_max_rpm) + 1) * 64'(cfg_edges_per_rev)) + 1;
         if (fast_limit > floor_p) floor_p = fast_limit;
      end
      gen_time = last_edge_time;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            gen_time += TIME_W'(floor_p)
                        + $urandom_range(0, (floor_p > 64'h3FFF_FFFF) ? 0 : 32'(floor_p * 3));
            stamp = gen_time;
         end else if (pick < 84) begin
            stamp = gen_time + $urandom_range(0, cfg_min_period - 1);
         end else if (pick < 92 && floor_p > cfg_min_period) begin
            gen_time += $urandom_range(cfg_min_period, 32'(floor_p - 1));
            stamp = gen_time;
         end else begin
            stamp = $urandom;
         end
         pending_edges.push_back(stamp);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Default settings: first edge, max boundary, bounce, too fast, timer wrap
      pending_edges.push_back(32'd12000);
      pending_edges.push_back(32'd21999);
      pending_edges.push_back(32'd22000);
      pending_edges.push_back(32'd34001);
      pending_edges.push_back(32'hFFFF_F000);
      pending_edges.push_back(32'h0000_3E20);
      pending_edges.push_back(32'hFFFF_FFFF);
      wait_idle();

      // No debounce: zero period, then speeds beyond what the rpm field holds
      phase_setting = '{32'd0, 8'd255, 16'hFFFF};
      apply_setting(phase_setting);
      pending_edges.push_back(32'hFFFF_FFFF);
      pending_edges.push_back(32'h0000_0000);
      pending_edges.push_back(32'd4000);
      wait_idle();

      // Zero pulses per revolution suppresses every reading
      phase_setting = '{32'd1, 8'd0, 16'hFFFF};
      apply_setting(phase_setting);
      pending_edges.push_back(32'd5000);
      pending_edges.push_back(32'd5000);
      wait_idle();

      // Widest debounce window with only zero rpm reported
      phase_setting = '{32'hFFFF_FFFF, 8'd1, 16'd0};
      apply_setting(phase_setting);
      pending_edges.push_back(32'd4999);
      pending_edges.push_back(32'd5000);
      pending_edges.push_back(32'd4998);
      wait_idle();

      // Top of the rpm range
      phase_setting = '{32'd1, 8'd1, 16'hFFFF};
      apply_setting(phase_setting);
      pending_edges.push_back(32'd5914);
      pending_edges.push_back(32'd6829);
      pending_edges.push_back(32'd6830);
      wait_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: phase_setting = '{32'd10000, 8'd1, 16'd5000};
            1: phase_setting = '{32'd1, 8'd1, 16'hFFFF};
            2: phase_setting = '{32'd500, 8'd4, 16'hFFFF};
            3: phase_setting = '{32'd2000, 8'd255, 16'd100};
            4: phase_setting = '{32'd100000, 8'd2, 16'd300};
            5: phase_setting = '{32'd1, 8'd7, 16'd0};
            default: phase_setting = '{$urandom_range(1, 50000), 8'($urandom_range(1, 255)),
                                       16'($urandom_range(0, 65535))};
         endcase
         apply_setting(phase_setting);
         queue_edges(EDGES_PER_PHASE);
         wait_idle();
      end

      $display("Edges sent: %0d, readings checked: %0d of %0d predicted",
               edges_taken, readings_checked, readings_due);
      $display("Register settings exercised: %0d (%0d register writes), mismatches: %0d",
               settings_run, csr_writes, mismatch_count);
      if (mismatch_count == 0 && expected_readings.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
